[design/object_tree_table_unit_defines.svh]
// ----------------------------------------------------------------------------
// object tree table unit: assertion macros
// shared helpers for the concurrent checks on the unit's ports
// ----------------------------------------------------------------------------
`ifndef OBJECT_TREE_TABLE_UNIT_DEFINES_SVH
`define OBJECT_TREE_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define OTTU_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("object tree table unit check failed");

// next-cycle implication, sampled on clk, off while in reset
`define OTTU_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("object tree table unit check failed");

`endif

[design/ottu_pkg.sv]
// ----------------------------------------------------------------------------
// ottu_pkg
// types, action codes and microcode definitions for the object tree table unit
// ----------------------------------------------------------------------------
package ottu_pkg;

	localparam int MAX_OBJECTS_DEF = 255;
	localparam int ATTR_COUNT_DEF  = 32;
	localparam int LINK_W          = 8;
	localparam int ATTR_WORD_W     = 32;
	localparam int UPC_W           = 5;

	// action codes
	typedef logic [3:0] action_t;
	localparam action_t ACT_LOAD      = 4'd0;
	localparam action_t ACT_INSERT    = 4'd1;
	localparam action_t ACT_REMOVE    = 4'd2;
	localparam action_t ACT_TEST_ATTR = 4'd3;
	localparam action_t ACT_SET_ATTR  = 4'd4;
	localparam action_t ACT_CLR_ATTR  = 4'd5;
	localparam action_t ACT_PARENT    = 4'd6;
	localparam action_t ACT_CHILD     = 4'd7;
	localparam action_t ACT_SIBLING   = 4'd8;
	localparam action_t ACT_PAR_EQ    = 4'd9;

	// request transaction
	typedef struct packed {
		action_t                  action;
		logic [LINK_W-1:0]        object_num;
		logic [LINK_W-1:0]        target_num;
		logic [4:0]               attribute_num;
		logic [LINK_W-1:0]        load_sibling;
		logic [LINK_W-1:0]        load_child;
		logic [ATTR_WORD_W-1:0]   load_attributes;
	} req_t;

	// response transaction
	typedef struct packed {
		logic [LINK_W-1:0] value;
		logic              condition;
		logic              error;
	} rsp_t;

	// microcode fields
	typedef logic [UPC_W-1:0] upc_t;

	typedef enum logic [1:0] {
		RD_NONE = 2'd0,
		RD_OBJ  = 2'd1,
		RD_TGT  = 2'd2,
		RD_LNK  = 2'd3
	} rd_sel_t;

	typedef enum logic [1:0] {
		WA_OBJ = 2'd0,
		WA_TGT = 2'd1,
		WA_LNK = 2'd2
	} wa_sel_t;

	typedef enum logic [2:0] {
		W_LOAD       = 3'd0,
		W_ATTR_SET   = 3'd1,
		W_ATTR_CLR   = 3'd2,
		W_CHILD_OSIB = 3'd3,
		W_SIB_OSIB   = 3'd4,
		W_CLR_LINKS  = 3'd5,
		W_INSERT_O   = 3'd6,
		W_CHILD_OBJ  = 3'd7
	} wop_t;

	typedef enum logic [2:0] {
		L_NONE       = 3'd0,
		L_OROW       = 3'd1,
		L_WALK_START = 3'd2,
		L_NEXT       = 3'd3,
		L_TCHILD     = 3'd4
	} lat_t;

	typedef enum logic [2:0] {
		C_NEVER      = 3'd0,
		C_ALWAYS     = 3'd1,
		C_DISPATCH   = 3'd2,
		C_PAR_ZERO   = 3'd3,
		C_LNK_BAD    = 3'd4,
		C_CHILD_IS_O = 3'd5,
		C_SIB_IS_O   = 3'd6,
		C_IS_REMOVE  = 3'd7
	} jc_t;

	typedef enum logic [1:0] {
		F_NONE = 2'd0,
		F_DONE = 2'd1,
		F_ERR  = 2'd2
	} fin_t;

	typedef enum logic [2:0] {
		R_ZERO   = 3'd0,
		R_PARENT = 3'd1,
		R_CHILD  = 3'd2,
		R_SIB    = 3'd3,
		R_PEQ    = 3'd4,
		R_TEST   = 3'd5
	} res_t;

	// one control word
	typedef struct packed {
		rd_sel_t rd;
		logic    wr;
		wa_sel_t wa;
		wop_t    wop;
		lat_t    lat;
		jc_t     jc;
		upc_t    jt;
		fin_t    fin;
		res_t    res;
	} uword_t;

	// status from the datapath to the sequencer
	typedef struct packed {
		action_t act;
		logic    obj_ok;
		logic    tgt_ok;
		logic    attr_ok;
		logic    par_zero;
		logic    lnk_bad;
		logic    child_is_o;
		logic    sib_is_o;
	} flags_t;

	// program addresses
	localparam upc_t UPC_DISP     = 5'd0;
	localparam upc_t UPC_LOAD     = 5'd1;
	localparam upc_t UPC_TEST     = 5'd2;
	localparam upc_t UPC_SET      = 5'd3;
	localparam upc_t UPC_CLR      = 5'd4;
	localparam upc_t UPC_PAR      = 5'd5;
	localparam upc_t UPC_CHILD    = 5'd6;
	localparam upc_t UPC_SIB      = 5'd7;
	localparam upc_t UPC_PEQ      = 5'd8;
	localparam upc_t UPC_ERR      = 5'd9;
	localparam upc_t UPC_ZERO     = 5'd10;
	localparam upc_t UPC_UNLINK   = 5'd11;
	localparam upc_t UPC_U_PAR    = 5'd12;
	localparam upc_t UPC_U_CHK    = 5'd13;
	localparam upc_t UPC_U_WSTART = 5'd14;
	localparam upc_t UPC_U_PFIX   = 5'd15;
	localparam upc_t UPC_U_WALK   = 5'd16;
	localparam upc_t UPC_U_WCHK   = 5'd17;
	localparam upc_t UPC_U_WNEXT  = 5'd18;
	localparam upc_t UPC_U_SFIX   = 5'd19;
	localparam upc_t UPC_U_CLR    = 5'd20;
	localparam upc_t UPC_U_CLRW   = 5'd21;
	localparam upc_t UPC_U_OK     = 5'd22;
	localparam upc_t UPC_I_RT     = 5'd23;
	localparam upc_t UPC_I_RO     = 5'd24;
	localparam upc_t UPC_I_WO     = 5'd25;
	localparam upc_t UPC_I_RT2    = 5'd26;
	localparam upc_t UPC_I_WT     = 5'd27;

endpackage

[design/ottu_ucode_rom.sv]
// ----------------------------------------------------------------------------
// ottu_ucode_rom
// control store: one control word for each program step
// ----------------------------------------------------------------------------
module ottu_ucode_rom (
	input  ottu_pkg::upc_t   pc,
	output ottu_pkg::uword_t uw
);
	import ottu_pkg::*;

	always_comb begin
		uw = '0;
		case (pc)
			// fetch the object row, branch on the action
			UPC_DISP: begin
				uw.rd = RD_OBJ;
				uw.jc = C_DISPATCH;
			end
			UPC_LOAD: begin
				uw.wr  = 1'b1;
				uw.wa  = WA_OBJ;
				uw.wop = W_LOAD;
				uw.fin = F_DONE;
			end
			UPC_TEST: begin
				uw.fin = F_DONE;
				uw.res = R_TEST;
			end
			UPC_SET: begin
				uw.wr  = 1'b1;
				uw.wa  = WA_OBJ;
				uw.wop = W_ATTR_SET;
				uw.fin = F_DONE;
			end
			UPC_CLR: begin
				uw.wr  = 1'b1;
				uw.wa  = WA_OBJ;
				uw.wop = W_ATTR_CLR;
				uw.fin = F_DONE;
			end
			UPC_PAR: begin
				uw.fin = F_DONE;
				uw.res = R_PARENT;
			end
			UPC_CHILD: begin
				uw.fin = F_DONE;
				uw.res = R_CHILD;
			end
			UPC_SIB: begin
				uw.fin = F_DONE;
				uw.res = R_SIB;
			end
			UPC_PEQ: begin
				uw.fin = F_DONE;
				uw.res = R_PEQ;
			end
			UPC_ERR: begin
				uw.fin = F_ERR;
			end
			UPC_ZERO: begin
				uw.fin = F_DONE;
			end
			// unlink: keep sibling and parent of the object
			UPC_UNLINK: begin
				uw.lat = L_OROW;
				uw.jc  = C_PAR_ZERO;
				uw.jt  = UPC_U_OK;
			end
			UPC_U_PAR: begin
				uw.rd = RD_LNK;
				uw.jc = C_LNK_BAD;
				uw.jt = UPC_ERR;
			end
			UPC_U_CHK: begin
				uw.jc = C_CHILD_IS_O;
				uw.jt = UPC_U_PFIX;
			end
			UPC_U_WSTART: begin
				uw.lat = L_WALK_START;
				uw.jc  = C_ALWAYS;
				uw.jt  = UPC_U_WALK;
			end
			// object is the first child: parent takes its sibling
			UPC_U_PFIX: begin
				uw.wr  = 1'b1;
				uw.wa  = WA_LNK;
				uw.wop = W_CHILD_OSIB;
				uw.jc  = C_ALWAYS;
				uw.jt  = UPC_U_CLR;
			end
			// sibling chain walk
			UPC_U_WALK: begin
				uw.rd = RD_LNK;
				uw.jc = C_LNK_BAD;
				uw.jt = UPC_ERR;
			end
			UPC_U_WCHK: begin
				uw.jc = C_SIB_IS_O;
				uw.jt = UPC_U_SFIX;
			end
			UPC_U_WNEXT: begin
				uw.lat = L_NEXT;
				uw.jc  = C_ALWAYS;
				uw.jt  = UPC_U_WALK;
			end
			UPC_U_SFIX: begin
				uw.wr  = 1'b1;
				uw.wa  = WA_LNK;
				uw.wop = W_SIB_OSIB;
			end
			// clear parent and sibling of the object
			UPC_U_CLR: begin
				uw.rd = RD_OBJ;
			end
			UPC_U_CLRW: begin
				uw.wr  = 1'b1;
				uw.wa  = WA_OBJ;
				uw.wop = W_CLR_LINKS;
			end
			UPC_U_OK: begin
				uw.jc = C_IS_REMOVE;
				uw.jt = UPC_ZERO;
			end
			// insert as first child of the target
			UPC_I_RT: begin
				uw.rd = RD_TGT;
			end
			UPC_I_RO: begin
				uw.rd  = RD_OBJ;
				uw.lat = L_TCHILD;
			end
			UPC_I_WO: begin
				uw.wr  = 1'b1;
				uw.wa  = WA_OBJ;
				uw.wop = W_INSERT_O;
			end
			UPC_I_RT2: begin
				uw.rd = RD_TGT;
			end
			UPC_I_WT: begin
				uw.wr  = 1'b1;
				uw.wa  = WA_TGT;
				uw.wop = W_CHILD_OBJ;
				uw.fin = F_DONE;
			end
			default: begin
				uw.fin = F_ERR;
			end
		endcase
	end

endmodule

[design/ottu_row_mem.sv]
// ----------------------------------------------------------------------------
// ottu_row_mem
// object row store, one write and one registered read port, with a valid flag
// per row so that rows never written read as zero
// ----------------------------------------------------------------------------
module ottu_row_mem #(
	parameter int ADDR_W = $clog2(ottu_pkg::MAX_OBJECTS_DEF + 1),
	parameter int DATA_W = 3 * ottu_pkg::LINK_W + ottu_pkg::ATTR_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);
	localparam int DEPTH = 2 ** ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [DATA_W-1:0] rdat_q;
	logic              rvld_q;

	// storage array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdat_q <= mem[rd_addr];
		end
	end

	// row valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rvld_q ? rdat_q : '0;

endmodule

[design/ottu_seq.sv]
// ----------------------------------------------------------------------------
// ottu_seq
// step counter with dispatch and conditional jumps over the control store
// ----------------------------------------------------------------------------
module ottu_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             out_blocked,
	input  ottu_pkg::uword_t uw,
	input  ottu_pkg::flags_t flags,
	output ottu_pkg::upc_t   pc,
	output logic             busy,
	output logic             go
);
	import ottu_pkg::*;

	upc_t pc_q;
	logic busy_q;
	upc_t disp_pc;
	upc_t jump_pc;
	logic taken;

	// entry point per action, argument checks first
	always_comb begin
		disp_pc = UPC_ZERO;
		if (flags.act > ACT_PAR_EQ) begin
			disp_pc = UPC_ZERO;
		end else if (!flags.obj_ok) begin
			disp_pc = UPC_ERR;
		end else begin
			case (flags.act)
				ACT_LOAD:      disp_pc = UPC_LOAD;
				ACT_INSERT:    disp_pc = flags.tgt_ok ? UPC_UNLINK : UPC_ERR;
				ACT_REMOVE:    disp_pc = UPC_UNLINK;
				ACT_TEST_ATTR: disp_pc = flags.attr_ok ? UPC_TEST : UPC_ERR;
				ACT_SET_ATTR:  disp_pc = flags.attr_ok ? UPC_SET : UPC_ERR;
				ACT_CLR_ATTR:  disp_pc = flags.attr_ok ? UPC_CLR : UPC_ERR;
				ACT_PARENT:    disp_pc = UPC_PAR;
				ACT_CHILD:     disp_pc = UPC_CHILD;
				ACT_SIBLING:   disp_pc = UPC_SIB;
				ACT_PAR_EQ:    disp_pc = UPC_PEQ;
				default:       disp_pc = UPC_ZERO;
			endcase
		end
	end

	// jump condition
	always_comb begin
		case (uw.jc)
			C_NEVER:      taken = 1'b0;
			C_ALWAYS:     taken = 1'b1;
			C_DISPATCH:   taken = 1'b1;
			C_PAR_ZERO:   taken = flags.par_zero;
			C_LNK_BAD:    taken = flags.lnk_bad;
			C_CHILD_IS_O: taken = flags.child_is_o;
			C_SIB_IS_O:   taken = flags.sib_is_o;
			C_IS_REMOVE:  taken = (flags.act == ACT_REMOVE);
			default:      taken = 1'b0;
		endcase
		jump_pc = (uw.jc == C_DISPATCH) ? disp_pc : uw.jt;
	end

	// a finishing step holds while the previous response is still waiting
	assign go = busy_q && !((uw.fin != F_NONE) && out_blocked);

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= UPC_DISP;
			busy_q <= 1'b0;
		end else if (start) begin
			pc_q   <= UPC_DISP;
			busy_q <= 1'b1;
		end else if (go) begin
			if (uw.fin != F_NONE) begin
				busy_q <= 1'b0;
				pc_q   <= UPC_DISP;
			end else if (taken) begin
				pc_q <= jump_pc;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	assign pc   = pc_q;
	assign busy = busy_q;

endmodule

[design/object_tree_table_unit.sv]
// ----------------------------------------------------------------------------
// object_tree_table_unit
// object table with parent, child and sibling links and attribute flags,
// run by a microcoded sequencer over a single row memory
// ----------------------------------------------------------------------------
//  channel | direction | payload | handshake
//  req     | in        | req_t   | req_valid / req_ready
//  rsp     | out       | rsp_t   | rsp_valid / rsp_ready
//
//  reads, load and attribute actions answer quickest; remove time depends on
//  whether the object has no parent, is the first child or how many siblings
//  are walked; insert adds its own steps; all use the one memory read port
//  rows read as zero after reset through per-row valid flags, no clearing pass
//  one transaction is worked at a time; a finished response waits in the
//  output register while the next request is taken
// ----------------------------------------------------------------------------
module object_tree_table_unit #(
	parameter int MAX_OBJECTS = ottu_pkg::MAX_OBJECTS_DEF,
	parameter int ATTR_COUNT  = ottu_pkg::ATTR_COUNT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  ottu_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ottu_pkg::rsp_t rsp
);
	import ottu_pkg::*;

	localparam int IDX_W      = $clog2(MAX_OBJECTS + 1);
	localparam int ATTR_IDX_W = $clog2(ATTR_COUNT);
	localparam int ROW_W      = 3 * LINK_W + ATTR_COUNT;
	localparam int PAR_LSB    = 2 * LINK_W + ATTR_COUNT;
	localparam int SIB_LSB    = LINK_W + ATTR_COUNT;
	localparam int CHD_LSB    = ATTR_COUNT;
	localparam logic [LINK_W-1:0] MAX_LINK = LINK_W'(MAX_OBJECTS);

	// request registers
	action_t                 act_q;
	logic [LINK_W-1:0]       obj_q;
	logic [LINK_W-1:0]       tgt_q;
	logic [4:0]              attr_q;
	logic [LINK_W-1:0]       lsib_q;
	logic [LINK_W-1:0]       lchild_q;
	logic [ATTR_COUNT-1:0]   lattr_q;

	// working registers
	logic [LINK_W-1:0]       lnk_q;
	logic [LINK_W-1:0]       osib_q;
	logic [LINK_W-1:0]       tchild_q;
	logic [IDX_W-1:0]        steps_q;

	// response register
	rsp_t                    rsp_q;
	logic                    rsp_valid_q;

	// control
	upc_t                    pc;
	uword_t                  uw;
	flags_t                  flags;
	logic                    busy;
	logic                    go;
	logic                    start;

	// memory side
	logic [ROW_W-1:0]        rdat;
	logic [ROW_W-1:0]        wdat;
	logic [IDX_W-1:0]        rd_addr;
	logic [IDX_W-1:0]        wr_addr;
	logic                    rd_en;
	logic                    wr_en;

	// row fields
	logic [LINK_W-1:0]       r_par, r_sib, r_chd;
	logic [ATTR_COUNT-1:0]   r_attr;
	logic [LINK_W-1:0]       w_par, w_sib, w_chd;
	logic [ATTR_COUNT-1:0]   w_attr;
	logic [ATTR_IDX_W-1:0]   bsel;
	rsp_t                    rsp_d;

	assign start     = req_valid && req_ready;
	assign req_ready = !busy;

	ottu_ucode_rom u_rom (
		.pc (pc),
		.uw (uw)
	);

	ottu_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.out_blocked (rsp_valid_q && !rsp_ready),
		.uw          (uw),
		.flags       (flags),
		.pc          (pc),
		.busy        (busy),
		.go          (go)
	);

	ottu_row_mem #(
		.ADDR_W (IDX_W),
		.DATA_W (ROW_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rdat),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wdat)
	);

	// capture the request transaction
	always_ff @(posedge clk) begin
		if (start) begin
			act_q    <= req.action;
			obj_q    <= req.object_num;
			tgt_q    <= req.target_num;
			attr_q   <= req.attribute_num;
			lsib_q   <= req.load_sibling;
			lchild_q <= req.load_child;
			lattr_q  <= req.load_attributes[ATTR_WORD_W-1 -: ATTR_COUNT];
		end
	end

	// row unpacking and attribute bit position
	assign r_par  = rdat[PAR_LSB +: LINK_W];
	assign r_sib  = rdat[SIB_LSB +: LINK_W];
	assign r_chd  = rdat[CHD_LSB +: LINK_W];
	assign r_attr = rdat[ATTR_COUNT-1:0];
	assign bsel   = ATTR_IDX_W'(ATTR_COUNT - 1) - attr_q[ATTR_IDX_W-1:0];

	// status for the sequencer
	always_comb begin
		flags            = '0;
		flags.act        = act_q;
		flags.obj_ok     = (obj_q != '0) && (obj_q <= MAX_LINK);
		flags.tgt_ok     = (tgt_q != '0) && (tgt_q <= MAX_LINK);
		flags.attr_ok    = ({1'b0, attr_q} < 6'(ATTR_COUNT));
		flags.par_zero   = (r_par == '0);
		flags.lnk_bad    = (lnk_q == '0) || (lnk_q > MAX_LINK) ||
		                   (steps_q >= IDX_W'(MAX_OBJECTS));
		flags.child_is_o = (r_chd == obj_q);
		flags.sib_is_o   = (r_sib == obj_q);
	end

	// memory addressing
	always_comb begin
		case (uw.rd)
			RD_OBJ:  rd_addr = obj_q[IDX_W-1:0];
			RD_TGT:  rd_addr = tgt_q[IDX_W-1:0];
			RD_LNK:  rd_addr = lnk_q[IDX_W-1:0];
			default: rd_addr = obj_q[IDX_W-1:0];
		endcase
		case (uw.wa)
			WA_OBJ:  wr_addr = obj_q[IDX_W-1:0];
			WA_TGT:  wr_addr = tgt_q[IDX_W-1:0];
			WA_LNK:  wr_addr = lnk_q[IDX_W-1:0];
			default: wr_addr = obj_q[IDX_W-1:0];
		endcase
	end

	assign rd_en = go && (uw.rd != RD_NONE);
	assign wr_en = go && uw.wr;

	// row update, read-modify-write on the last row read
	always_comb begin
		w_par  = r_par;
		w_sib  = r_sib;
		w_chd  = r_chd;
		w_attr = r_attr;
		case (uw.wop)
			W_LOAD: begin
				w_par  = tgt_q;
				w_sib  = lsib_q;
				w_chd  = lchild_q;
				w_attr = lattr_q;
			end
			W_ATTR_SET:   w_attr[bsel] = 1'b1;
			W_ATTR_CLR:   w_attr[bsel] = 1'b0;
			W_CHILD_OSIB: w_chd = osib_q;
			W_SIB_OSIB:   w_sib = osib_q;
			W_CLR_LINKS: begin
				w_par = '0;
				w_sib = '0;
			end
			W_INSERT_O: begin
				w_par = tgt_q;
				w_sib = tchild_q;
			end
			W_CHILD_OBJ:  w_chd = obj_q;
			default:      w_chd = r_chd;
		endcase
		wdat = {w_par, w_sib, w_chd, w_attr};
	end

	// link pointer, saved sibling and walk count
	always_ff @(posedge clk) begin
		if (go) begin
			case (uw.lat)
				L_OROW: begin
					osib_q  <= r_sib;
					lnk_q   <= r_par;
					steps_q <= '0;
				end
				L_WALK_START: lnk_q <= r_chd;
				L_NEXT: begin
					lnk_q   <= r_sib;
					steps_q <= steps_q + 1'b1;
				end
				L_TCHILD: tchild_q <= r_chd;
				default: lnk_q <= lnk_q;
			endcase
		end
	end

	// response value
	always_comb begin
		rsp_d = '0;
		if (uw.fin == F_ERR) begin
			rsp_d.error = 1'b1;
		end else begin
			case (uw.res)
				R_PARENT: rsp_d.value = r_par;
				R_CHILD: begin
					rsp_d.value     = r_chd;
					rsp_d.condition = (r_chd != '0);
				end
				R_SIB: begin
					rsp_d.value     = r_sib;
					rsp_d.condition = (r_sib != '0);
				end
				R_PEQ:   rsp_d.condition = (r_par == tgt_q);
				R_TEST:  rsp_d.condition = r_attr[bsel];
				default: rsp_d = '0;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (go && (uw.fin != F_NONE)) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (go && (uw.fin != F_NONE)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[design/ottu_checker.sv]
// ----------------------------------------------------------------------------
// ottu_checker
// port-level checks for the object tree table unit, bound to the top level
// ----------------------------------------------------------------------------
`include "object_tree_table_unit_defines.svh"

module ottu_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input ottu_pkg::rsp_t rsp
);
	import ottu_pkg::*;

	logic [1:0] pend_q;
	logic       req_fire;
	logic       rsp_fire;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	// transactions taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else if (req_fire && !rsp_fire) begin
			pend_q <= pend_q + 2'd1;
		end else if (rsp_fire && !req_fire) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	`OTTU_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	`OTTU_ASSERT_NXT(a_busy_after_req, req_fire, !req_ready)
	`OTTU_ASSERT_IMP(a_err_clean, rsp_valid && rsp.error, rsp.value == '0 && !rsp.condition)
	`OTTU_ASSERT_IMP(a_no_orphan, rsp_valid, pend_q != 2'd0)
	`OTTU_ASSERT_IMP(a_pend_bound, req_valid || rsp_valid, pend_q != 2'd3)

endmodule

bind object_tree_table_unit ottu_checker u_ottu_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: object tree table unit testbench
// drives load, insert, remove, attribute and link actions through the request
// channel and checks every response against a behavioural copy of the tables
// ----------------------------------------------------------------------------
module tb_top;
	import ottu_pkg::*;

	localparam int      MAX_OBJ        = 255;
	localparam int      N_RANDOM       = 500;
	localparam int      QUIET_TAIL     = 60;
	localparam int      PRESSURE_AT    = 150;
	localparam int      PRESSURE_LEN   = 80;
	localparam int      SETTLE_CYCLES  = 20;
	// longest legal action is a walk over the whole sibling loop plus an insert
	localparam int      STALL_LIMIT    = 4000;
	localparam action_t ACT_UNUSED_LO  = 4'd10;
	localparam action_t ACT_UNUSED_HI  = 4'd15;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// behavioural copy of the object tables
	logic [7:0]  parent_of  [256];
	logic [7:0]  sibling_of [256];
	logic [7:0]  child_of   [256];
	logic [31:0] attr_of    [256];

	req_t req_pending_q [$];
	rsp_t rsp_expected_q [$];

	int   items_total = 0;
	int   items_taken = 0;
	int   fail_count = 0;
	int   idle_cycles = 0;

	// driver private state
	int   req_gap = 0;
	int   req_gap_pct = 20;
	logic drv_valid_nxt;
	req_t drv_req_nxt;

	// monitor private state
	int   rsp_seen = 0;
	int   rsp_stall = 0;
	int   rsp_hold = 0;
	int   rsp_stall_pct = 20;
	logic mon_ready_nxt;
	rsp_t rsp_want;

	object_tree_table_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// unlink an object from its parent; 0 on a broken chain, tables untouched
	function automatic bit detach(logic [7:0] obj);
		logic [7:0] par;
		logic [7:0] cur;
		int         steps;
		bit         found;
		par = parent_of[obj];
		if (par == 8'd0)
			return 1'b1;
		if (child_of[par] == obj) begin
			child_of[par] = sibling_of[obj];
		end else begin
			cur = child_of[par];
			steps = 0;
			found = 1'b0;
			while (!found) begin
				if (cur == 8'd0 || steps >= MAX_OBJ)
					return 1'b0;
				if (sibling_of[cur] == obj) begin
					found = 1'b1;
				end else begin
					cur = sibling_of[cur];
					steps++;
				end
			end
			sibling_of[cur] = sibling_of[obj];
		end
		parent_of[obj] = 8'd0;
		sibling_of[obj] = 8'd0;
		return 1'b1;
	endfunction

	// apply one action to the tables and work out its response
	function automatic rsp_t tree_predict(req_t r);
		rsp_t       res;
		logic [7:0] o;
		logic [7:0] t;
		logic [31:0] flag;
		res = '0;
		o = r.object_num;
		t = r.target_num;
		flag = 32'h8000_0000 >> r.attribute_num;
		if (r.action > ACT_PAR_EQ)
			return res;
		if (o == 8'd0) begin
			res.error = 1'b1;
			return res;
		end
		case (r.action)
			ACT_LOAD: begin
				parent_of[o] = t;
				sibling_of[o] = r.load_sibling;
				child_of[o] = r.load_child;
				// all 32 flags are kept at the full attribute count
				attr_of[o] = r.load_attributes;
			end
			ACT_INSERT: begin
				if (t == 8'd0 || !detach(o)) begin
					res.error = 1'b1;
				end else begin
					sibling_of[o] = child_of[t];
					parent_of[o] = t;
					child_of[t] = o;
				end
			end
			ACT_REMOVE:    res.error = !detach(o);
			ACT_TEST_ATTR: res.condition = |(attr_of[o] & flag);
			ACT_SET_ATTR:  attr_of[o] = attr_of[o] | flag;
			ACT_CLR_ATTR:  attr_of[o] = attr_of[o] & ~flag;
			ACT_PARENT:    res.value = parent_of[o];
			ACT_CHILD: begin
				res.value = child_of[o];
				res.condition = child_of[o] != 8'd0;
			end
			ACT_SIBLING: begin
				res.value = sibling_of[o];
				res.condition = sibling_of[o] != 8'd0;
			end
			default:       res.condition = parent_of[o] == t;
		endcase
		return res;
	endfunction

	function automatic void add(action_t act, logic [7:0] o, logic [7:0] t = 8'd0,
			logic [4:0] a = 5'd0, logic [7:0] ls = 8'd0, logic [7:0] lc = 8'd0,
			logic [31:0] la = 32'd0);
		req_t r;
		r.action = act;
		r.object_num = o;
		r.target_num = t;
		r.attribute_num = a;
		r.load_sibling = ls;
		r.load_child = lc;
		r.load_attributes = la;
		req_pending_q.push_back(r);
	endfunction

	// mostly a small pool so that trees form, sometimes anything
	function automatic logic [7:0] pick_obj();
		if ($urandom_range(0, 99) < 88)
			return 8'($urandom_range(1, 16));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_link();
		if ($urandom_range(0, 2) == 0)
			return 8'd0;
		return pick_obj();
	endfunction

	function automatic void add_random();
		int         sel;
		action_t    act;
		logic [7:0] t;
		logic [7:0] ls;
		logic [7:0] lc;
		sel = $urandom_range(0, 99);
		t = 8'($urandom_range(0, 255));
		ls = 8'($urandom_range(0, 255));
		lc = 8'($urandom_range(0, 255));
		if (sel < 6) begin
			act = ACT_LOAD;
			// half the loads detach cleanly, the rest leave odd links behind
			if ($urandom_range(0, 1) == 0) begin
				t = 8'd0;
				ls = 8'd0;
				lc = 8'd0;
			end else begin
				t = pick_link();
				ls = pick_link();
				lc = pick_link();
			end
		end else if (sel < 36) begin
			act = ACT_INSERT;
			t = ($urandom_range(0, 19) == 0) ? 8'd0 : pick_obj();
		end else if (sel < 52) begin
			act = ACT_REMOVE;
		end else if (sel < 58) begin
			act = ACT_TEST_ATTR;
		end else if (sel < 64) begin
			act = ACT_SET_ATTR;
		end else if (sel < 70) begin
			act = ACT_CLR_ATTR;
		end else if (sel < 77) begin
			act = ACT_PARENT;
		end else if (sel < 84) begin
			act = ACT_CHILD;
		end else if (sel < 91) begin
			act = ACT_SIBLING;
		end else if (sel < 97) begin
			act = ACT_PAR_EQ;
			t = pick_link();
		end else begin
			act = action_t'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
		end
		add(act, pick_obj(), t, 5'($urandom_range(0, 31)), ls, lc, $urandom());
	endfunction

	// stimulus, reset and end of run
	initial begin
		for (int i = 0; i < 256; i++) begin
			parent_of[i] = 8'd0;
			sibling_of[i] = 8'd0;
			child_of[i] = 8'd0;
			attr_of[i] = 32'd0;
		end

		// invalid object, attribute extremes
		add(ACT_PARENT, 8'd0);
		add(ACT_LOAD, 8'd255, 8'd0, 5'd0, 8'd0, 8'd0, 32'hFFFF_FFFF);
		add(ACT_TEST_ATTR, 8'd255, 8'd0, 5'd0);
		add(ACT_CLR_ATTR, 8'd255, 8'd0, 5'd0);
		add(ACT_TEST_ATTR, 8'd255, 8'd0, 5'd0);
		add(ACT_TEST_ATTR, 8'd255, 8'd0, 5'd31);
		add(ACT_SET_ATTR, 8'd1, 8'd0, 5'd31);
		// build a family under object 2, then remove by walk, as first child, with no parent
		add(ACT_INSERT, 8'd1, 8'd2);
		add(ACT_INSERT, 8'd3, 8'd2);
		add(ACT_INSERT, 8'd4, 8'd2);
		add(ACT_REMOVE, 8'd1);
		add(ACT_REMOVE, 8'd4);
		add(ACT_REMOVE, 8'd5);
		// invalid target, then self insert
		add(ACT_INSERT, 8'd3, 8'd0);
		add(ACT_INSERT, 8'd6, 8'd6);
		add(ACT_CHILD, 8'd2);
		add(ACT_SIBLING, 8'd3);
		add(ACT_PARENT, 8'd3);
		add(ACT_PAR_EQ, 8'd3, 8'd2);
		// sibling loop that never reaches the object: walk runs over the bound
		add(ACT_LOAD, 8'd10, 8'd20);
		add(ACT_LOAD, 8'd20, 8'd0, 5'd0, 8'd0, 8'd30);
		add(ACT_LOAD, 8'd30, 8'd0, 5'd0, 8'd30, 8'd0, 32'h5555_5555);
		add(ACT_REMOVE, 8'd10);
		// chain that ends before the object
		add(ACT_LOAD, 8'd12, 8'd2, 5'd0, 8'd255, 8'd255, 32'hAAAA_AAAA);
		add(ACT_INSERT, 8'd12, 8'd1);
		add(ACT_UNUSED_HI, 8'd7, 8'd255, 5'd31);

		for (int i = 0; i < N_RANDOM; i++)
			add_random();
		items_total = req_pending_q.size();

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (items_taken < items_total)
			@(posedge clk);
		while (rsp_expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (rsp_expected_q.size() != 0) begin
			$error("%0d responses never arrived", rsp_expected_q.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			drv_valid_nxt = req_valid;
			drv_req_nxt = req;
			if (req_valid && req_ready) begin
				rsp_expected_q.push_back(tree_predict(req));
				items_taken <= items_taken + 1;
				drv_valid_nxt = 1'b0;
				// change the idling mood now and then, quiet stretches included
				if ((items_taken + 1) % 50 == 0) begin
					case ($urandom_range(0, 2))
						0:       req_gap_pct = 0;
						1:       req_gap_pct = 15;
						default: req_gap_pct = 40;
					endcase
				end
			end
			if (!drv_valid_nxt) begin
				if (req_gap > 0) begin
					req_gap--;
				end else if (req_pending_q.size() != 0) begin
					if (items_taken < items_total - QUIET_TAIL &&
							$urandom_range(0, 99) < req_gap_pct) begin
						req_gap = $urandom_range(0, 4);
					end else begin
						drv_valid_nxt = 1'b1;
						drv_req_nxt = req_pending_q.pop_front();
					end
				end
			end
			req_valid <= drv_valid_nxt;
			req <= drv_req_nxt;
		end
	end

	// response monitor and back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (rsp_expected_q.size() == 0) begin
					$error("response with no transaction outstanding");
					fail_count++;
				end else begin
					rsp_want = rsp_expected_q.pop_front();
					if (rsp.value !== rsp_want.value) begin
						$error("value: expected %0d, got %0d", rsp_want.value, rsp.value);
						fail_count++;
					end
					if (rsp.condition !== rsp_want.condition) begin
						$error("condition: expected %0d, got %0d",
							rsp_want.condition, rsp.condition);
						fail_count++;
					end
					if (rsp.error !== rsp_want.error) begin
						$error("error: expected %0d, got %0d", rsp_want.error, rsp.error);
						fail_count++;
					end
				end
				rsp_seen++;
				// one long hold so the unit fills up and pushes back on requests
				if (rsp_seen == PRESSURE_AT)
					rsp_hold = PRESSURE_LEN;
				if (rsp_seen % 50 == 0)
					rsp_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
			end
			if (rsp_hold > 0) begin
				rsp_hold--;
				mon_ready_nxt = 1'b0;
			end else if (rsp_stall > 0) begin
				rsp_stall--;
				mon_ready_nxt = 1'b0;
			end else if (rsp_seen < items_total - QUIET_TAIL &&
					$urandom_range(0, 99) < rsp_stall_pct) begin
				rsp_stall = $urandom_range(0, 4);
				mon_ready_nxt = 1'b0;
			end else begin
				mon_ready_nxt = 1'b1;
			end
			rsp_ready <= mon_ready_nxt;
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$error("no progress for %0d cycles", STALL_LIMIT);
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

endmodule
